// ----- hdl/fdsa_pkg.sv -----
// Package for the Forth data stack ALU: opcodes, status codes, operand tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fdsa_pkg;
	localparam int DEF_STACK_DEPTH = 16;
	localparam int WORD_W = 32;
	localparam int OP_W = 5;
	localparam int ST_W = 2;
	localparam int DEPTH_W = 5;

	localparam logic [OP_W-1:0] OP_PUSH = 5'd0;
	localparam logic [OP_W-1:0] OP_ADD = 5'd1;
	localparam logic [OP_W-1:0] OP_SUB = 5'd2;
	localparam logic [OP_W-1:0] OP_MUL = 5'd3;
	localparam logic [OP_W-1:0] OP_DIV = 5'd4;
	localparam logic [OP_W-1:0] OP_DROP = 5'd5;
	localparam logic [OP_W-1:0] OP_DUP = 5'd6;
	localparam logic [OP_W-1:0] OP_SWAP = 5'd7;
	localparam logic [OP_W-1:0] OP_OVER = 5'd8;
	localparam logic [OP_W-1:0] OP_ROT = 5'd9;
	localparam logic [OP_W-1:0] OP_2SWAP = 5'd10;
	localparam logic [OP_W-1:0] OP_2OVER = 5'd11;
	localparam logic [OP_W-1:0] OP_2DUP = 5'd12;
	localparam logic [OP_W-1:0] OP_MOD = 5'd13;
	localparam logic [OP_W-1:0] OP_DIVMOD = 5'd14;
	localparam logic [OP_W-1:0] OP_EQ = 5'd15;
	localparam logic [OP_W-1:0] OP_LT = 5'd16;
	localparam logic [OP_W-1:0] OP_GT = 5'd17;
	localparam logic [OP_W-1:0] OP_AND = 5'd18;
	localparam logic [OP_W-1:0] OP_OR = 5'd19;
	localparam logic [OP_W-1:0] OP_INVERT = 5'd20;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
	localparam logic [ST_W-1:0] ST_OVER = 2'd2;
	localparam logic [ST_W-1:0] ST_DIVZ = 2'd3;

	typedef struct packed {
		logic [2:0] need;
		logic [1:0] grow;
		logic shrink;
		logic valid;
	} op_info_t;

	function automatic op_info_t op_info(input logic [OP_W-1:0] op);
		op_info_t r;
		r = '{need: 3'd0, grow: 2'd0, shrink: 1'b0, valid: 1'b1};
		unique case (op)
			OP_PUSH: r.grow = 2'd1;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR: begin
				r.need = 3'd2;
				r.shrink = 1'b1;
			end
			OP_DROP: begin
				r.need = 3'd1;
				r.shrink = 1'b1;
			end
			OP_DUP: begin
				r.need = 3'd1;
				r.grow = 2'd1;
			end
			OP_SWAP, OP_DIVMOD: r.need = 3'd2;
			OP_OVER: begin
				r.need = 3'd2;
				r.grow = 2'd1;
			end
			OP_ROT: r.need = 3'd3;
			OP_2SWAP: r.need = 3'd4;
			OP_2OVER: begin
				r.need = 3'd4;
				r.grow = 2'd2;
			end
			OP_2DUP: begin
				r.need = 3'd2;
				r.grow = 2'd2;
			end
			OP_INVERT: r.need = 3'd1;
			default: r.valid = 1'b0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic start;
	} div_ctl_t;
endpackage
`default_nettype wire

// ----- hdl/fdsa_div.sv -----
// Radix-2 restoring divider, signed truncating, one quotient bit per cycle.
// Depends on fdsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdsa_div
	import fdsa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire div_ctl_t ctl,
	input wire logic [WORD_W-1:0] dividend,
	input wire logic [WORD_W-1:0] divisor,
	output logic done,
	output logic [WORD_W-1:0] quot,
	output logic [WORD_W-1:0] rem
);
	logic [WORD_W-1:0] q_q, d_q;
	logic [WORD_W:0] r_q;
	logic [5:0] cnt_q;
	logic busy_q, qneg_q, rneg_q;
	logic [WORD_W:0] trial;
	logic [WORD_W:0] shifted;

	assign shifted = {r_q[WORD_W-1:0], q_q[WORD_W-1]};
	assign trial = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= dividend[WORD_W-1] ? -dividend : dividend;
			d_q <= divisor[WORD_W-1] ? -divisor : divisor;
			r_q <= '0;
			rneg_q <= dividend[WORD_W-1];
			qneg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				r_q <= trial;
				q_q <= {q_q[WORD_W-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign quot = qneg_q ? -q_q : q_q;
	assign rem = rneg_q ? -r_q[WORD_W-1:0] : r_q[WORD_W-1:0];
endmodule
`default_nettype wire

// ----- hdl/forth_data_stack_alu.sv -----
// Channel    | ports                          | handshake
// command    | opcode, literal                | start & !busy
// result     | status, top_value, depth       | done strobe, one cycle
// busy covers the read, execute, write, top-fetch and done states. An undefined
// op or a failed depth check goes from the first read straight to the top fetch,
// a zero divisor skips the write, and div, mod and /mod wait on the 32-step
// bit-serial divider. done rises in the same cycle that busy drops; results
// cannot be stalled. Stack words live in a one-port RAM, one access per cycle.
// Reset clears count, sequencer and done only. Depends on fdsa_pkg, fdsa_div.
`timescale 1ns / 1ps
`default_nettype none
module forth_data_stack_alu
	import fdsa_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [OP_W-1:0] opcode,
	input wire logic signed [WORD_W-1:0] literal,
	output logic done,
	output logic [ST_W-1:0] status,
	output logic signed [WORD_W-1:0] top_value,
	output logic [DEPTH_W-1:0] depth
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_RDW = 4'd2;
	localparam logic [3:0] S_EXEC = 4'd3;
	localparam logic [3:0] S_DIV = 4'd4;
	localparam logic [3:0] S_WR = 4'd5;
	localparam logic [3:0] S_TOP = 4'd6;
	localparam logic [3:0] S_TOPW = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] st_q;
	logic [WORD_W-1:0] mem [STACK_DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [AW-1:0] addr;
	logic we;
	logic [WORD_W-1:0] wd;
	logic [CW-1:0] cnt_q, newcnt_q;
	logic [OP_W-1:0] op_q;
	logic [WORD_W-1:0] lit_q;
	logic [WORD_W-1:0] w_q [4];
	logic [WORD_W-1:0] o_q [4];
	logic [2:0] ri_q, wi_q, nw_q;
	logic [CW-1:0] wbase_q;
	logic [ST_W-1:0] stat_q;
	op_info_t info;
	div_ctl_t dctl;
	logic ddone;
	logic [WORD_W-1:0] dq, dr;
	logic [WORD_W-1:0] a, b;
	logic [CW:0] grown;
	logic [CW-1:0] rd_base;

	assign info = op_info(op_q);
	assign a = w_q[1];
	assign b = w_q[0];
	assign grown = {1'b0, cnt_q} + {{(CW-1){1'b0}}, info.grow} - {{CW{1'b0}}, info.shrink};
	assign busy = st_q != S_IDLE;
	assign rd_base = cnt_q - CW'(ri_q) - CW'(1);

	always_comb begin
		addr = '0;
		we = 1'b0;
		wd = o_q[wi_q[1:0]];
		unique case (st_q)
			S_RD: addr = rd_base[AW-1:0];
			S_WR: begin
				addr = AW'(wbase_q + CW'(wi_q));
				we = wi_q < nw_q;
			end
			S_TOP: addr = AW'(newcnt_q - CW'(1));
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	fdsa_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl),
		.dividend(a), .divisor(b), .done(ddone), .quot(dq), .rem(dr)
	);

	always_comb begin
		dctl.start = (st_q == S_EXEC) && (op_q == OP_DIV || op_q == OP_MOD || op_q == OP_DIVMOD)
			&& (b != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) st_q <= S_RD;
				S_RD: begin
					if (!info.valid) st_q <= S_TOP;
					else if (cnt_q < CW'(info.need)) st_q <= S_TOP;
					else if (grown > (CW+1)'(STACK_DEPTH)) st_q <= S_TOP;
					else if (ri_q == info.need || ri_q == 3'd4) st_q <= S_EXEC;
					else st_q <= S_RDW;
				end
				S_RDW: st_q <= S_RD;
				S_EXEC: begin
					if (dctl.start) st_q <= S_DIV;
					else if (stat_q == ST_DIVZ || (op_q inside {OP_DIV, OP_MOD, OP_DIVMOD}))
						st_q <= S_TOP;
					else st_q <= S_WR;
				end
				S_DIV: if (ddone) st_q <= S_WR;
				S_WR: if (wi_q + 3'd1 >= nw_q) begin
					st_q <= S_TOP;
					cnt_q <= newcnt_q;
				end
				S_TOP: st_q <= S_TOPW;
				S_TOPW: st_q <= S_DONE;
				S_DONE: begin
					st_q <= S_IDLE;
					done <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				op_q <= opcode;
				lit_q <= literal;
				ri_q <= '0;
				wi_q <= '0;
				nw_q <= '0;
				stat_q <= ST_OK;
				newcnt_q <= cnt_q;
			end
			S_RD: begin
				if (!info.valid) stat_q <= ST_OK;
				else if (cnt_q < CW'(info.need)) stat_q <= ST_UNDER;
				else if (grown > (CW+1)'(STACK_DEPTH)) stat_q <= ST_OVER;
				newcnt_q <= cnt_q;
			end
			S_RDW: begin
				ri_q <= ri_q + 3'd1;
			end
			S_EXEC: begin
				newcnt_q <= grown[CW-1:0];
				wbase_q <= cnt_q - CW'(info.need);
				if ((op_q inside {OP_DIV, OP_MOD, OP_DIVMOD}) && b == '0) begin
					stat_q <= ST_DIVZ;
					newcnt_q <= cnt_q;
				end
				nw_q <= '0;
				case (op_q)
					OP_PUSH: begin o_q[0] <= lit_q; nw_q <= 3'd1; end
					OP_ADD: begin o_q[0] <= a + b; nw_q <= 3'd1; end
					OP_SUB: begin o_q[0] <= a - b; nw_q <= 3'd1; end
					OP_MUL: begin o_q[0] <= a * b; nw_q <= 3'd1; end
					OP_DIV, OP_MOD: nw_q <= 3'd1;
					OP_DIVMOD: nw_q <= 3'd2;
					OP_DUP: begin o_q[0] <= b; o_q[1] <= b; nw_q <= 3'd2; end
					OP_SWAP: begin o_q[0] <= b; o_q[1] <= a; nw_q <= 3'd2; end
					OP_OVER: begin
						o_q[0] <= a; o_q[1] <= b; o_q[2] <= a; nw_q <= 3'd3;
					end
					OP_ROT: begin
						o_q[0] <= a; o_q[1] <= b; o_q[2] <= w_q[2]; nw_q <= 3'd3;
					end
					OP_2SWAP: begin
						o_q[0] <= a; o_q[1] <= b; o_q[2] <= w_q[3]; o_q[3] <= w_q[2];
						nw_q <= 3'd4;
					end
					OP_2OVER: begin
						o_q[0] <= w_q[3]; o_q[1] <= w_q[2];
						wbase_q <= cnt_q; nw_q <= 3'd2;
					end
					OP_2DUP: begin
						o_q[0] <= a; o_q[1] <= b; wbase_q <= cnt_q; nw_q <= 3'd2;
					end
					OP_EQ: begin o_q[0] <= {WORD_W{a == b}}; nw_q <= 3'd1; end
					OP_LT: begin
						o_q[0] <= {WORD_W{$signed(a) < $signed(b)}}; nw_q <= 3'd1;
					end
					OP_GT: begin
						o_q[0] <= {WORD_W{$signed(a) > $signed(b)}}; nw_q <= 3'd1;
					end
					OP_AND: begin o_q[0] <= {WORD_W{&a && &b}}; nw_q <= 3'd1; end
					OP_OR: begin o_q[0] <= {WORD_W{&a || &b}}; nw_q <= 3'd1; end
					OP_INVERT: begin o_q[0] <= {WORD_W{~&b}}; nw_q <= 3'd1; end
					default: nw_q <= '0;
				endcase
				if (op_q == OP_PUSH) wbase_q <= cnt_q;
				if (op_q == OP_DUP) wbase_q <= cnt_q - CW'(1);
				if (op_q == OP_OVER) wbase_q <= cnt_q - CW'(2);
			end
			S_DIV: if (ddone) begin
				o_q[0] <= (op_q == OP_DIV) ? dq : dr;
				o_q[1] <= dq;
			end
			S_WR: wi_q <= wi_q + 3'd1;
			S_TOPW: top_value <= (newcnt_q == '0) ? '0 : rd_q;
			default: ;
		endcase
		if (st_q == S_RDW) w_q[ri_q[1:0]] <= rd_q;
	end

	assign status = stat_q;
	assign depth = DEPTH_W'(cnt_q);

`ifndef NO_ASSERTIONS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(STACK_DEPTH))
		else $error("count over depth");
	a_done: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n) we |-> stat_q == ST_OK)
		else $error("write on failed op");
`endif
endmodule
`default_nettype wire

// ----- sim/forth_data_stack_alu_test.sv -----
// Self-checking testbench for forth_data_stack_alu: directed table, then random op sequences.
// Results are predicted by a behavioral stack model kept in this file. Depends on fdsa_pkg, forth_data_stack_alu.
`timescale 1ns / 1ps
module forth_data_stack_alu_test;
	import fdsa_pkg::*;

	localparam int DEPTH_MAX = DEF_STACK_DEPTH;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [ST_W-1:0] st;
		logic [WORD_W-1:0] top;
		logic [DEPTH_W-1:0] dep;
	} stack_result_t;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [WORD_W-1:0] lit;
		bit known;
		stack_result_t res;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] opcode = '0;
	logic signed [WORD_W-1:0] literal = '0;
	logic busy, done;
	logic [ST_W-1:0] status;
	logic signed [WORD_W-1:0] top_value;
	logic [DEPTH_W-1:0] depth;

	forth_data_stack_alu u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .literal(literal), .done(done),
		.status(status), .top_value(top_value), .depth(depth)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [WORD_W-1:0] model_words [DEPTH_MAX];
	int model_count = 0;
	stack_result_t pending_results [$];
	int mismatches = 0;
	int idle_cycles = 0;

	function automatic logic [WORD_W-1:0] flag_of(bit c);
		return c ? '1 : '0;
	endfunction

	function automatic stack_result_t predict_step(logic [OP_W-1:0] op, logic [WORD_W-1:0] lit);
		int need, grow, n;
		logic [WORD_W-1:0] a, b, c, w0, w1;
		longint sa, sb;
		stack_result_t r;
		n = model_count;
		r.st = ST_OK;
		need = 0;
		grow = 0;
		case (op)
			OP_PUSH: grow = 1;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_LT, OP_GT, OP_AND,
			OP_OR: begin
				need = 2;
				grow = -1;
			end
			OP_DROP: begin
				need = 1;
				grow = -1;
			end
			OP_DUP: begin
				need = 1;
				grow = 1;
			end
			OP_SWAP, OP_DIVMOD: need = 2;
			OP_OVER: begin
				need = 2;
				grow = 1;
			end
			OP_ROT: need = 3;
			OP_2SWAP: need = 4;
			OP_2OVER: begin
				need = 4;
				grow = 2;
			end
			OP_2DUP: begin
				need = 2;
				grow = 2;
			end
			OP_INVERT: need = 1;
			default: need = -1;
		endcase
		if (need >= 0) begin
			b = n >= 1 ? model_words[n-1] : '0;
			a = n >= 2 ? model_words[n-2] : '0;
			sa = $signed(a);
			sb = $signed(b);
			if (n < need) r.st = ST_UNDER;
			else if (n + grow > DEPTH_MAX) r.st = ST_OVER;
			else if ((op == OP_DIV || op == OP_MOD || op == OP_DIVMOD) && b == '0)
				r.st = ST_DIVZ;
			else begin
				case (op)
					OP_PUSH: model_words[n] = lit;
					OP_ADD: model_words[n-2] = a + b;
					OP_SUB: model_words[n-2] = a - b;
					OP_MUL: model_words[n-2] = a * b;
					OP_DIV: model_words[n-2] = WORD_W'(sa / sb);
					OP_DUP: model_words[n] = b;
					OP_SWAP: begin
						model_words[n-2] = b;
						model_words[n-1] = a;
					end
					OP_OVER: model_words[n] = a;
					OP_ROT: begin
						c = model_words[n-3];
						model_words[n-3] = a;
						model_words[n-2] = b;
						model_words[n-1] = c;
					end
					OP_2SWAP: begin
						w0 = model_words[n-4];
						w1 = model_words[n-3];
						model_words[n-4] = a;
						model_words[n-3] = b;
						model_words[n-2] = w0;
						model_words[n-1] = w1;
					end
					OP_2OVER: begin
						w0 = model_words[n-4];
						w1 = model_words[n-3];
						model_words[n] = w0;
						model_words[n+1] = w1;
					end
					OP_2DUP: begin
						model_words[n] = a;
						model_words[n+1] = b;
					end
					OP_MOD: model_words[n-2] = WORD_W'(sa % sb);
					OP_DIVMOD: begin
						model_words[n-2] = WORD_W'(sa % sb);
						model_words[n-1] = WORD_W'(sa / sb);
					end
					OP_EQ: model_words[n-2] = flag_of(a == b);
					OP_LT: model_words[n-2] = flag_of(sa < sb);
					OP_GT: model_words[n-2] = flag_of(sa > sb);
					OP_AND: model_words[n-2] = flag_of(a == '1 && b == '1);
					OP_OR: model_words[n-2] = flag_of(a == '1 || b == '1);
					OP_INVERT: model_words[n-1] = flag_of(b != '1);
					default: ;
				endcase
				model_count = n + grow;
			end
		end
		r.top = model_count > 0 ? model_words[model_count-1] : '0;
		r.dep = model_count[DEPTH_W-1:0];
		return r;
	endfunction

	// directed rows; known=1 rows carry a hand-typed expectation
	cmd_row_t directed_rows [] = '{
		'{OP_DROP, 32'h0, 1'b1, '{ST_UNDER, 32'h0, 5'd0}},
		'{OP_INVERT, 32'h0, 1'b1, '{ST_UNDER, 32'h0, 5'd0}},
		'{5'd31, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd0}},
		'{OP_PUSH, 32'h8000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 5'd1}},
		'{OP_DUP, 32'h0, 1'b1, '{ST_OK, 32'h8000_0000, 5'd2}},
		'{OP_ADD, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd1}},
		'{OP_PUSH, 32'h0, 1'b1, '{ST_OK, 32'h0, 5'd2}},
		'{OP_DIV, 32'h0, 1'b1, '{ST_DIVZ, 32'h0, 5'd2}},
		'{OP_MOD, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_DIVMOD, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_DROP, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_PUSH, 32'h8000_0000, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_PUSH, 32'hFFFF_FFFF, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_DIV, 32'h0, 1'b1, '{ST_OK, 32'h8000_0000, 5'd2}},
		'{OP_PUSH, 32'h7FFF_FFFF, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_PUSH, 32'hFFFF_FFFF, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_2SWAP, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_2OVER, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_ROT, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_2DUP, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_OVER, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_SWAP, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_AND, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_OR, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}},
		'{OP_EQ, 32'h0, 1'b0, '{ST_OK, 32'h0, 5'd0}}
	};

	task automatic send_command(logic [OP_W-1:0] op, logic [WORD_W-1:0] lit,
		bit known, stack_result_t want);
		stack_result_t r;
		start <= 1'b1;
		opcode <= op;
		literal <= lit;
		do @(posedge clk); while (busy);
		r = predict_step(op, lit);
		if (known && r != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row op %0d: typed %h, predicted %h", op, want, r);
		end
		pending_results.push_back(r);
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			4: return $urandom_range(0, 7) - 3;
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		stack_result_t w, got;
		if (done) begin
			got = '{status, top_value, depth};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				w = pending_results.pop_front();
				if (w != got) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d top %h/%h depth %0d/%0d",
							w.st, got.st, w.top, got.top, w.dep, got.dep);
				end
			end
		end
		if (done || (start && !busy)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int burst;
		logic [OP_W-1:0] op;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_command(directed_rows[i].op, directed_rows[i].lit,
				directed_rows[i].known, directed_rows[i].res);
		wait (pending_results.size() == 0);
		@(posedge clk);
		for (int k = 0; k < 1100; k += burst) begin
			burst = $urandom_range(1, 40);
			for (int j = 0; j < burst; j++) begin
				// bias toward pushes when shallow so deep ops and overflow both occur
				if ($urandom_range(0, 15) == 0) op = OP_W'($urandom_range(21, 31));
				else if ($urandom_range(0, 9) < (model_count < 4 ? 6 : 2)) op = OP_PUSH;
				else op = OP_W'($urandom_range(1, 20));
				send_command(op, random_word(), 1'b0, '0);
			end
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 60)) @(posedge clk);
			if (k % 300 < burst) wait (pending_results.size() == 0);
		end
		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#4;
	end
endmodule
